[design/itoa_pkg.sv]
package itoa_pkg;

  // conversion codes carried in the low bits of the input tuser
  typedef enum logic [1:0] {
    FUNC_SDEC = 2'd0,
    FUNC_UDEC = 2'd1,
    FUNC_HEX  = 2'd2,
    FUNC_CHAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_ONE,
    ST_EMIT
  } state_t;

  // start command for the serial binary-to-bcd unit
  typedef struct packed {
    logic start;
    logic wide;
  } bcd_cmd_t;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned HALF_W     = VALUE_W / 2;
  localparam int unsigned DEC_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
  localparam int unsigned STEP_W     = $clog2(VALUE_W);

  localparam logic [4:0] DIGITS_DEC  = 5'd20;
  localparam logic [4:0] DIGITS_HEXW = 5'd16;
  localparam logic [4:0] DIGITS_HEXN = 5'd8;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ALPHA = 8'h57;  // 'a' minus ten

  // room demanded for one conversion, never less than its worst-case length
  function automatic logic [4:0] need_len(input func_t func, input logic wide);
    logic [4:0] n;
    begin
      n = 5'd1;
      unique case (func)
        FUNC_SDEC: n = wide ? 5'd21 : 5'd12;
        FUNC_UDEC: n = wide ? 5'd21 : 5'd11;
        FUNC_HEX:  n = wide ? 5'd17 : 5'd9;
        FUNC_CHAR: n = 5'd1;
        default:   n = 5'd1;
      endcase
      return n;
    end
  endfunction

  // lower-case digit for one nibble, also serves bcd digits
  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    begin
      return (nib < 4'd10) ? (CHAR_ZERO + {4'b0, nib}) : (CHAR_ALPHA + {4'b0, nib});
    end
  endfunction

endpackage

[design/integer_to_ascii_formatter.sv]
// integer_to_ascii_formatter
//
// input channel (s_*): one word per value. tuser carries the conversion code
// and the width flag, tdata the raw value and the free room. the block takes
// one value at a time; s_tready is high only while nothing is in progress.
// output channel (m_*): one ascii character per word, tlast on the final
// character, tuser set on the single word sent when the room is too small.
//
// steps per value, from acceptance:
//   character or no-room: 1 word
//   hex: 8 or 16 words, one per cycle unless the receiver stalls
//   decimal: bit-serial double dabble over 32 bits narrow or 64 wide, then
//   the digits are loaded and the leading zeros dropped (up to 19), then the
//   sign and the digits at one word per cycle unless the receiver stalls
// the double dabble loop is the longest step of a decimal conversion.
// a registered output word decouples the sides: a stalled receiver holds
// the word and the emitter waits; nothing is lost or repeated.
// reset (rst, synchronous) returns to idle and drops any pending word.
module integer_to_ascii_formatter
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // value [63:0], room [69:64], zero fill
  input  logic [2:0]  s_tuser,   // func [1:0], wide [2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // character [7:0]
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // no_room [0]
);

  // input fields
  func_t              in_func;
  logic               in_wide;
  logic [VALUE_W-1:0] in_value;
  logic [5:0]         in_room;

  assign in_func  = func_t'(s_tuser[1:0]);
  assign in_wide  = s_tuser[2];
  assign in_value = s_tdata[63:0];
  assign in_room  = s_tdata[69:64];

  state_t             state, state_next;
  logic [BCD_W-1:0]   digits, digits_next;   // digit at the top goes out next
  logic [4:0]         remain, remain_next;   // digits still to send
  logic               neg, neg_next;
  logic [7:0]         one_char, one_char_next;
  logic               one_nr, one_nr_next;

  logic               slot_free;
  logic               out_load;
  logic [7:0]         out_char;
  logic               out_last;
  logic               out_nr;

  bcd_cmd_t           cmd;
  logic               bcd_done;
  logic [BCD_W-1:0]   bcd;

  // magnitude for the decimal paths
  logic [VALUE_W-1:0] sval;
  logic [VALUE_W-1:0] mag;
  logic               in_neg;

  assign sval   = in_wide ? in_value : {{HALF_W{in_value[HALF_W-1]}}, in_value[HALF_W-1:0]};
  assign in_neg = (in_func == FUNC_SDEC) && sval[VALUE_W-1];
  // the most negative value comes out right through the unsigned negate
  assign mag    = in_neg ? (VALUE_W'(0) - sval) : sval;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  itoa_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .mag  (mag),
    .done (bcd_done),
    .bcd  (bcd)
  );

  always_comb begin
    state_next    = state;
    digits_next   = digits;
    remain_next   = remain;
    neg_next      = neg;
    one_char_next = one_char;
    one_nr_next   = one_nr;
    out_load      = 1'b0;
    out_char      = 8'h00;
    out_last      = 1'b0;
    out_nr        = 1'b0;
    cmd.start     = 1'b0;
    cmd.wide      = in_wide;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_room < {1'b0, need_len(in_func, in_wide)}) begin
            // too little room: one flagged word, nothing converted
            one_char_next = 8'h00;
            one_nr_next   = 1'b1;
            state_next    = ST_ONE;
          end else begin
            case (in_func)
              FUNC_CHAR: begin
                one_char_next = in_value[7:0];
                one_nr_next   = 1'b0;
                state_next    = ST_ONE;
              end
              FUNC_HEX: begin
                digits_next = in_wide ? {in_value, 16'h0000}
                                      : {in_value[HALF_W-1:0], 48'h0};
                remain_next = in_wide ? DIGITS_HEXW : DIGITS_HEXN;
                state_next  = ST_EMIT;
              end
              default: begin
                cmd.start  = 1'b1;
                neg_next   = in_neg;
                state_next = ST_CONV;
              end
            endcase
          end
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          digits_next = bcd;
          remain_next = DIGITS_DEC;
          state_next  = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (remain > 5'd1 && digits[BCD_W-1 -: 4] == 4'd0) begin
          digits_next = {digits[BCD_W-5:0], 4'd0};
          remain_next = remain - 5'd1;
        end else begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char   = CHAR_MINUS;
          neg_next   = 1'b0;
          state_next = ST_EMIT;
        end
      end
      ST_ONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char   = one_char;
          out_last   = 1'b1;
          out_nr     = one_nr;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_char    = digit_char(digits[BCD_W-1 -: 4]);
          out_last    = (remain == 5'd1);
          digits_next = {digits[BCD_W-5:0], 4'd0};
          remain_next = remain - 5'd1;
          if (remain == 5'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      neg      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      neg   <= neg_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    digits   <= digits_next;
    remain   <= remain_next;
    one_char <= one_char_next;
    one_nr   <= one_nr_next;
    if (out_load) begin
      m_tdata    <= out_char;
      m_tlast    <= out_last;
      m_tuser[0] <= out_nr;
    end
  end

  // an accepted value blocks the input until its run is done
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a conversion is in progress");

  // a new word never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output word overwritten");

  // the bcd unit only finishes while a decimal conversion waits on it
  a_bcd_done_state: assert property (@(posedge clk) disable iff (rst)
    bcd_done |-> state == ST_CONV)
    else $error("bcd result outside conversion state");

  // emitting always has a digit left
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> remain != 5'd0)
    else $error("emit state with no digits left");

  // a no-room word is a lone zero word closing the run
  a_no_room_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
    else $error("malformed no-room word");

endmodule

[design/itoa_bcd.sv]
module itoa_bcd
  import itoa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  bcd_cmd_t             cmd,
  input  logic [VALUE_W-1:0]   mag,
  output logic                 done,
  output logic [BCD_W-1:0]     bcd
);

  logic                 busy;
  logic [STEP_W-1:0]    cnt;
  logic [VALUE_W-1:0]   shreg;
  logic [BCD_W-1:0]     adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bcd   <= '0;
      shreg <= cmd.wide ? mag : {mag[HALF_W-1:0], {HALF_W{1'b0}}};
      cnt   <= cmd.wide ? STEP_W'(VALUE_W - 1) : STEP_W'(HALF_W - 1);
    end else if (busy) begin
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_W-1]};
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
    end
  end

endmodule
